>>> rtl/hts_pkg.sv
package hts_pkg;

  localparam int unsigned InW     = 56;
  localparam int unsigned OutW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned GapW    = 26;

  localparam logic [9:0] MsPerSecond = 10'd1000;

  localparam logic [CfgIdxW-1:0] RegRuleEnabled  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOnLevel      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffLevel     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinGapSec    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGraceMs      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTargetId     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRulePriority = 3'd6;

  typedef struct packed {
    logic               rule_enabled;
    logic signed [15:0] on_level;
    logic signed [15:0] off_level;
    logic [GapW-1:0]    min_gap_ms;
    logic [31:0]        grace_ms;
    logic [7:0]         target_id;
    logic [7:0]         rule_priority;
  } cfg_t;

  typedef struct packed {
    logic               sample_usable;
    logic signed [15:0] sample_value;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic       applies;
    logic       drive_on;
    logic [7:0] verdict_target;
    logic [7:0] verdict_priority;
    logic       fault_shutoff;
  } verdict_t;

endpackage

>>> rtl/hts_cfg.sv
module hts_cfg
  import hts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output cfg_t               cfg
);

  logic [GapW-1:0] gap_product;

  // seconds to milliseconds, done once at the write
  assign gap_product = {10'd0, cfg_data[15:0]} * {16'd0, MsPerSecond};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegRuleEnabled:  cfg.rule_enabled  <= cfg_data[0];
        RegOnLevel:      cfg.on_level      <= signed'(cfg_data[15:0]);
        RegOffLevel:     cfg.off_level     <= signed'(cfg_data[15:0]);
        RegMinGapSec:    cfg.min_gap_ms    <= gap_product;
        RegGraceMs:      cfg.grace_ms      <= cfg_data;
        RegTargetId:     cfg.target_id     <= cfg_data[7:0];
        RegRulePriority: cfg.rule_priority <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/hts_core.sv
module hts_core
  import hts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  sample_t  smp,
  input  logic     fire,
  output verdict_t vd
);

  logic        active;
  logic        has_triggered;
  logic [31:0] last_change_ms;
  logic        suspect;
  logic [31:0] suspect_start_ms;

  logic        active_next;
  logic        has_triggered_next;
  logic [31:0] last_change_ms_next;
  logic        suspect_next;
  logic [31:0] suspect_start_ms_next;

  logic [31:0] start_ms;
  logic [31:0] bad_age;
  logic [31:0] change_age;
  logic        grace_up;
  logic        gap_ok;
  logic        want;
  logic        app;
  logic        on;
  logic        fault;

  assign start_ms   = suspect ? suspect_start_ms : smp.now_ms;
  assign bad_age    = smp.now_ms - start_ms;
  assign grace_up   = bad_age >= cfg.grace_ms;
  assign change_age = smp.now_ms - last_change_ms;
  assign gap_ok     = (cfg.min_gap_ms == '0) || !has_triggered ||
                      (change_age >= {6'd0, cfg.min_gap_ms});

  always_comb begin
    want = active;
    if (cfg.on_level < cfg.off_level) begin
      if (smp.sample_value <= cfg.on_level) begin
        want = 1'b1;
      end else if (smp.sample_value >= cfg.off_level) begin
        want = 1'b0;
      end
    end else begin
      if (smp.sample_value >= cfg.on_level) begin
        want = 1'b1;
      end else if (smp.sample_value <= cfg.off_level) begin
        want = 1'b0;
      end
    end
  end

  always_comb begin
    active_next           = active;
    has_triggered_next    = has_triggered;
    last_change_ms_next   = last_change_ms;
    suspect_next          = suspect;
    suspect_start_ms_next = suspect_start_ms;
    app   = 1'b0;
    on    = 1'b0;
    fault = 1'b0;
    if (cfg.rule_enabled) begin
      if (!smp.sample_usable) begin
        suspect_next          = 1'b1;
        suspect_start_ms_next = start_ms;
        if (!grace_up) begin
          // hold during grace
          app = active;
          on  = 1'b1;
        end else begin
          app = 1'b1;
          if (active) begin
            active_next         = 1'b0;
            last_change_ms_next = smp.now_ms;
            has_triggered_next  = 1'b1;
            fault               = 1'b1;
          end
        end
      end else begin
        suspect_next = 1'b0;
        app          = 1'b1;
        on           = want;
        if (want != active) begin
          if (gap_ok) begin
            active_next         = want;
            last_change_ms_next = smp.now_ms;
            has_triggered_next  = 1'b1;
          end else begin
            on = active;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      has_triggered    <= 1'b0;
      last_change_ms   <= '0;
      suspect          <= 1'b0;
      suspect_start_ms <= '0;
    end else if (fire) begin
      active           <= active_next;
      has_triggered    <= has_triggered_next;
      last_change_ms   <= last_change_ms_next;
      suspect          <= suspect_next;
      suspect_start_ms <= suspect_start_ms_next;
    end
  end

  assign vd.applies          = app;
  assign vd.drive_on         = app & on;
  assign vd.verdict_target   = app ? cfg.target_id : 8'd0;
  assign vd.verdict_priority = app ? cfg.rule_priority : 8'd0;
  assign vd.fault_shutoff    = app & fault;

endmodule

>>> rtl/hysteresis_threshold_rule.sv
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  sample_usable, sample_value, now_ms
// m_axis   out  m_axis_tvalid/m_axis_tready  applies, drive_on, target, priority, fault
// cfg      in   cfg_we                       cfg_index, cfg_data
//
// one beat per cycle sustained while m_axis is not stalled; a result passes from its
// input beat via the input register, then decision logic into the result register
// rst is synchronous: clears config, rule state and both valid flags
// a stalled m_axis holds the result register; the input register fills and
// s_axis_tready drops only when both are full
module hysteresis_threshold_rule
  import hts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // sample_usable, sample_value, now_ms, zero fill
  input  logic [InW-1:0]     s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // applies, drive_on, verdict_target, verdict_priority, fault_shutoff, zero fill
  output logic [OutW-1:0]    m_axis_tdata,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  cfg_t     cfg;
  sample_t  smp;
  verdict_t vd;
  verdict_t res;
  logic     smp_valid;
  logic     fire;

  hts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hts_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .smp  (smp),
    .fire (fire),
    .vd   (vd)
  );

  assign fire          = smp_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !smp_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (s_axis_tready) begin
      smp_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      smp.sample_usable <= s_axis_tdata[0];
      smp.sample_value  <= signed'(s_axis_tdata[16:1]);
      smp.now_ms        <= s_axis_tdata[48:17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= vd;
    end
  end

  assign m_axis_tdata = {5'd0, res.fault_shutoff, res.verdict_priority,
                         res.verdict_target, res.drive_on, res.applies};

endmodule

>>> rtl/hts_checker.sv
module hts_checker
  import hts_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [OutW-1:0]    m_axis_tdata
);

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no verdict means every other field is zero
  a_no_verdict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[18:1] == 18'd0)
    else $error("fields set without a verdict");

  // a fault shutoff is always an off verdict
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("fault shutoff without off verdict");

  // with no pending result and an empty pipe, input is taken
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) && !$past(rst)
      |-> s_axis_tready)
    else $error("input stalled with empty pipe");

endmodule

bind hysteresis_threshold_rule hts_checker u_hts_checker (.*);

>>> tb/tb_hysteresis_threshold_rule.sv
`timescale 1ns / 1ps

module tb_hysteresis_threshold_rule;
  import hts_pkg::*;

  typedef struct {
    bit                 enabled;
    logic signed [15:0] on_lvl;
    logic signed [15:0] off_lvl;
    logic [15:0]        gap_sec;
    logic [31:0]        grace;
    logic [7:0]         tgt;
    logic [7:0]         prio;
  } rule_cfg_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InW-1:0]     s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutW-1:0]    m_axis_tdata;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  // rule model state
  rule_cfg_t   cfg;
  bit          st_active;
  bit          st_triggered;
  logic [31:0] st_last_change;
  bit          st_suspect;
  logic [31:0] st_suspect_start;

  verdict_t verdict_q[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  int       errors;
  int       samples_sent;
  int       verdicts_seen;
  int       shutoffs;
  int       deferrals;
  int       no_verdicts;

  hysteresis_threshold_rule u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic bit ms_elapsed(logic [31:0] now, logic [31:0] since, logic [31:0] dur);
    logic [31:0] diff;
    diff = now - since;
    return diff >= dur;
  endfunction

  function automatic verdict_t give_verdict(bit on, bit fault);
    verdict_t v;
    v.applies          = 1'b1;
    v.drive_on         = on;
    v.verdict_target   = cfg.tgt;
    v.verdict_priority = cfg.prio;
    v.fault_shutoff    = fault;
    return v;
  endfunction

  function automatic verdict_t predict_verdict(bit usable, logic signed [15:0] val,
                                               logic [31:0] now);
    verdict_t    v;
    bit          want;
    bit          allowed;
    logic [31:0] gap_ms;
    v = '0;
    if (!cfg.enabled) begin
      no_verdicts++;
      return v;
    end
    if (!usable) begin
      if (!st_suspect) begin
        st_suspect       = 1'b1;
        st_suspect_start = now;
      end
      if (!ms_elapsed(now, st_suspect_start, cfg.grace)) begin
        if (st_active) return give_verdict(1'b1, 1'b0);
        no_verdicts++;
        return v;
      end
      if (st_active) begin
        st_active      = 1'b0;
        st_last_change = now;
        st_triggered   = 1'b1;
        shutoffs++;
        return give_verdict(1'b0, 1'b1);
      end
      return give_verdict(1'b0, 1'b0);
    end
    st_suspect = 1'b0;
    want = st_active;
    if (cfg.on_lvl < cfg.off_lvl) begin
      if (val <= cfg.on_lvl) want = 1'b1;
      else if (val >= cfg.off_lvl) want = 1'b0;
    end else begin
      if (val >= cfg.on_lvl) want = 1'b1;
      else if (val <= cfg.off_lvl) want = 1'b0;
    end
    if (want != st_active) begin
      gap_ms  = 32'(cfg.gap_sec) * 32'd1000;
      allowed = (cfg.gap_sec == 0) || !st_triggered ||
                ms_elapsed(now, st_last_change, gap_ms);
      if (!allowed) begin
        deferrals++;
        return give_verdict(st_active, 1'b0);
      end
      st_active      = want;
      st_last_change = now;
      st_triggered   = 1'b1;
    end
    return give_verdict(want, 1'b0);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("verdict %0d %s got %0h expected %0h",
                                verdicts_seen, name, got, exp_val));
  endtask

  // result side: random stalls and checking
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %0h", m_axis_tdata));
      end else begin
        exp_v = verdict_q.pop_front();
        check_field("applies", m_axis_tdata[0], exp_v.applies);
        check_field("drive_on", m_axis_tdata[1], exp_v.drive_on);
        check_field("verdict_target", m_axis_tdata[9:2], exp_v.verdict_target);
        check_field("verdict_priority", m_axis_tdata[17:10], exp_v.verdict_priority);
        check_field("fault_shutoff", m_axis_tdata[18], exp_v.fault_shutoff);
      end
      verdicts_seen++;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_sample(bit usable, logic signed [15:0] val, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now, val, usable};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    verdict_q.push_back(predict_verdict(usable, val, now));
    samples_sent++;
  endtask

  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(rule_cfg_t c);
    write_reg(RegRuleEnabled, {31'd0, c.enabled});
    write_reg(RegOnLevel, {{16{c.on_lvl[15]}}, c.on_lvl});
    write_reg(RegOffLevel, {16'd0, c.off_lvl});
    write_reg(RegMinGapSec, {16'd0, c.gap_sec});
    write_reg(RegGraceMs, c.grace);
    write_reg(RegTargetId, {24'd0, c.tgt});
    write_reg(RegRulePriority, {24'd0, c.prio});
    cfg_we <= 1'b0;
    cfg = c;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_level();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'sh8000;
    if (r < 16) return 16'sh7fff;
    if (r < 24) return 16'($urandom);
    return 16'($urandom_range(0, 4000) - 2000);
  endfunction

  function automatic rule_cfg_t random_rule();
    rule_cfg_t c;
    int        r;
    c.enabled = ($urandom_range(99) < 90);
    c.on_lvl  = random_level();
    c.off_lvl = ($urandom_range(99) < 8) ? c.on_lvl : random_level();
    r = $urandom_range(99);
    if (r < 45) c.gap_sec = 16'd0;
    else if (r < 92) c.gap_sec = 16'($urandom_range(1, 3));
    else if (r < 96) c.gap_sec = 16'hffff;
    else c.gap_sec = 16'($urandom);
    r = $urandom_range(99);
    if (r < 20) c.grace = 32'd0;
    else if (r < 80) c.grace = $urandom_range(1, 3000);
    else if (r < 90) c.grace = 32'hffff_ffff;
    else c.grace = $urandom;
    c.tgt  = 8'($urandom);
    c.prio = 8'($urandom);
    return c;
  endfunction

  task automatic test_disabled_rule();
    rule_cfg_t c;
    c = '{1'b0, 16'sh0100, -16'sh0100, 16'd1, 32'd10, 8'ha5, 8'h5a};
    apply_config(c);
    send_sample(1'b1, 16'sh7fff, 32'd5);
    send_sample(1'b0, 16'sh8000, 32'hffff_ffff);
    send_sample(1'b1, 16'sh0000, 32'd0);
    drain_verdicts();
  endtask

  task automatic test_low_side_drive();
    rule_cfg_t c;
    c = '{1'b1, 16'sh8000, 16'sh7fff, 16'd0, 32'd0, 8'hff, 8'h00};
    apply_config(c);
    send_sample(1'b1, 16'sh8000, 32'd100);
    send_sample(1'b1, 16'sh0000, 32'd101);
    send_sample(1'b1, 16'sh7fff, 32'd102);
    send_sample(1'b1, 16'sh8000, 32'd103);
    // zero grace: first unusable sample shuts the drive off
    send_sample(1'b0, 16'sh1234, 32'd104);
    send_sample(1'b0, 16'sh1234, 32'd105);
    drain_verdicts();
    c = '{1'b1, 16'sh7fff, 16'sh8000, 16'd0, 32'd0, 8'h3c, 8'hc3};
    apply_config(c);
    send_sample(1'b1, 16'sh7fff, 32'd200);
    send_sample(1'b1, 16'sh0000, 32'd201);
    send_sample(1'b1, 16'sh8000, 32'd202);
    drain_verdicts();
  endtask

  task automatic test_equal_levels_timing();
    rule_cfg_t   c;
    logic [31:0] t;
    c = '{1'b1, 16'sh0000, 16'sh0000, 16'd2, 32'd1000, 8'h00, 8'hff};
    apply_config(c);
    t = 32'hffff_fc00;
    send_sample(1'b1, 16'sh0000, t);
    send_sample(1'b1, -16'sh0001, t + 32'd500);
    // deferred change lands once two seconds have passed across the wrap
    send_sample(1'b1, -16'sh0001, t + 32'd1999);
    send_sample(1'b1, -16'sh0001, t + 32'd2000);
    send_sample(1'b0, 16'sh0000, t + 32'd2100);
    send_sample(1'b0, 16'sh0000, t + 32'd3099);
    send_sample(1'b0, 16'sh0000, t + 32'd3100);
    send_sample(1'b1, 16'sh0001, t + 32'd5000);
    send_sample(1'b0, 16'sh0000, t + 32'd5100);
    send_sample(1'b0, 16'sh0000, t + 32'd6100);
    drain_verdicts();
  endtask

  task automatic test_random_traffic(int items);
    rule_cfg_t          c;
    logic [31:0]        now;
    int                 seg_left;
    int                 r;
    int                 v;
    bit                 usable;
    logic signed [15:0] val;
    now = $urandom;
    seg_left = 0;
    for (int n = 0; n < items; n++) begin
      if (seg_left == 0) begin
        drain_verdicts();
        c = random_rule();
        apply_config(c);
        seg_left = $urandom_range(20, 80);
      end
      seg_left--;
      r = $urandom_range(99);
      if (r < 3) now = $urandom;
      else if (r < 85) now = now + $urandom_range(0, 600);
      else now = now + $urandom_range(600, 5000);
      usable = ($urandom_range(99) < 78);
      if ($urandom_range(99) < 15) begin
        val = 16'($urandom);
      end else begin
        v = ($urandom_range(1) ? int'(c.on_lvl) : int'(c.off_lvl)) +
            $urandom_range(0, 600) - 300;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        val = 16'(v);
      end
      send_sample(usable, val, now);
    end
    drain_verdicts();
  endtask

  initial begin
    cfg = '{1'b0, 16'sh0, 16'sh0, 16'd0, 32'd0, 8'd0, 8'd0};
    st_active = 1'b0;
    st_triggered = 1'b0;
    st_last_change = '0;
    st_suspect = 1'b0;
    st_suspect_start = '0;
    errors = 0;
    samples_sent = 0;
    verdicts_seen = 0;
    shutoffs = 0;
    deferrals = 0;
    no_verdicts = 0;
    send_idle_pct = 26;
    recv_idle_pct = 50;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_rule();
    test_low_side_drive();
    test_equal_levels_timing();
    test_random_traffic(350);
    send_idle_pct = 50;
    recv_idle_pct = 26;
    test_random_traffic(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(350);

    $display("run covered %0d samples and %0d verdict beats", samples_sent, verdicts_seen);
    $display("%0d fault shutoffs, %0d deferred changes, %0d no-verdict results",
             shutoffs, deferrals, no_verdicts);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
